FILE: rtl/core/b64se_pkg.sv
package b64se_pkg;

   // ASCII codes used by the alphabet
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] PAD_CHAR     = 8'h3D;

   // sextet boundaries of the alphabet
   localparam logic [5:0] SEXTET_LOWER = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT = 6'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;

   // position of the next byte within a three-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // up to four characters caused by one input item
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            eom;
   } entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // map one sextet onto the standard alphabet
   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] ch;
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < SEXTET_LOWER) begin
         ch = CHAR_UPPER_A + v8;
      end else if (v < SEXTET_DIGIT) begin
         ch = CHAR_LOWER_A + v8 - {2'b00, SEXTET_LOWER};
      end else if (v < SEXTET_PLUS) begin
         ch = CHAR_DIGIT_0 + v8 - {2'b00, SEXTET_DIGIT};
      end else if (v == SEXTET_PLUS) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

FILE: rtl/core/base64_stream_encoder_core.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_data_byte, req_final_byte
// rsp     | out       | rsp_valid / rsp_ready | rsp_code_char, rsp_last_of_item,
//         |           |                       | rsp_end_of_message
//
// One character leaves per cycle while the queue holds an item and the output
// is not stalled; an item gives 1, 2, 3 or 4 characters. The first character
// passes through the entry queue and then the output register before it is
// offered. The entry queue (QUEUE_DEPTH items) lets the input keep accepting
// while the output drains or stalls; once it is full req_ready drops until the
// last character of the head item is loaded into the output register.
// Synchronous reset empties the queue and returns to the start of a group.
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_char,
   output logic       rsp_last_of_item,
   output logic       rsp_end_of_message
);

   b64se_pkg::queue_status_type q_stat;
   b64se_pkg::entry_type        push_entry, head_entry;
   logic                        push, pop;

   b64se_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_stat         (q_stat),
      .push           (push),
      .push_entry     (push_entry)
   );

   b64se_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   b64se_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_entry         (head_entry),
      .q_stat             (q_stat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_char      (rsp_code_char),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

FILE: rtl/core/b64se_front.sv
module b64se_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_final_byte,
   input  b64se_pkg::queue_status_type  q_stat,
   output logic                         push,
   output b64se_pkg::entry_type         push_entry
);

   b64se_pkg::phase_type phase_ff, phase_in;
   logic [3:0]           carry_ff, carry_in;
   b64se_pkg::entry_type entry;

   assign req_ready  = !q_stat.full;
   assign push       = req_valid && req_ready;
   assign push_entry = entry;

   // split the byte into characters and advance the group position
   always_comb begin
      entry          = '0;
      entry.eom      = req_final_byte;
      phase_in       = b64se_pkg::PH_FIRST;
      carry_in       = 4'd0;
      unique case (phase_ff)
         b64se_pkg::PH_SECOND: begin
            entry.chars[0] = b64se_pkg::sextet_to_char({carry_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               entry.chars[1] = b64se_pkg::sextet_to_char({req_data_byte[3:0], 2'b00});
               entry.chars[2] = b64se_pkg::PAD_CHAR;
               entry.last_idx = 2'd2;
            end else begin
               entry.last_idx = 2'd0;
               phase_in       = b64se_pkg::PH_THIRD;
               carry_in       = req_data_byte[3:0];
            end
         end
         b64se_pkg::PH_THIRD: begin
            entry.chars[0] = b64se_pkg::sextet_to_char({carry_ff, req_data_byte[7:6]});
            entry.chars[1] = b64se_pkg::sextet_to_char(req_data_byte[5:0]);
            entry.last_idx = 2'd1;
         end
         default: begin
            entry.chars[0] = b64se_pkg::sextet_to_char(req_data_byte[7:2]);
            if (req_final_byte) begin
               entry.chars[1] = b64se_pkg::sextet_to_char({req_data_byte[1:0], 4'b0000});
               entry.chars[2] = b64se_pkg::PAD_CHAR;
               entry.chars[3] = b64se_pkg::PAD_CHAR;
               entry.last_idx = 2'd3;
            end else begin
               entry.last_idx = 2'd0;
               phase_in       = b64se_pkg::PH_SECOND;
               carry_in       = {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
   end

   // group state moves only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64se_pkg::PH_FIRST;
         carry_ff <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

FILE: rtl/core/b64se_queue.sv
module b64se_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  b64se_pkg::entry_type         push_entry,
   input  logic                         pop,
   output b64se_pkg::entry_type         head_entry,
   output b64se_pkg::queue_status_type  q_stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64se_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_entry   = entries_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/b64se_back.sv
module b64se_back (
   input  logic                         clock,
   input  logic                         reset,
   input  b64se_pkg::entry_type         head_entry,
   input  b64se_pkg::queue_status_type  q_stat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_code_char,
   output logic                         rsp_last_of_item,
   output logic                         rsp_end_of_message
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff, eom_ff;
   logic       load;
   logic       at_last;

   assign load    = !q_stat.empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head_entry.last_idx);
   assign pop     = load && at_last;

   assign rsp_valid          = valid_ff;
   assign rsp_code_char      = char_ff;
   assign rsp_last_of_item   = last_ff;
   assign rsp_end_of_message = eom_ff;

   // one character per cycle out of the head item while the output is not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head_entry.chars[idx_ff];
         last_ff <= at_last;
         eom_ff  <= at_last && head_entry.eom;
      end
   end

endmodule

FILE: rtl/core/b64se_checker.sv
module b64se_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_char,
   input logic       rsp_last_of_item,
   input logic       rsp_end_of_message
);

   // a message always ends on the last character of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_message |-> rsp_last_of_item)
   else $error("end of message without last of item");

   // padding closes an item only at the end of a message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_item && rsp_code_char == b64se_pkg::PAD_CHAR
      |-> rsp_end_of_message)
   else $error("pad ends an item outside end of message");

   // only alphabet characters or pad appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_char >= 8'h41 && rsp_code_char <= 8'h5A) ||
                    (rsp_code_char >= 8'h61 && rsp_code_char <= 8'h7A) ||
                    (rsp_code_char >= 8'h30 && rsp_code_char <= 8'h39) ||
                    rsp_code_char == b64se_pkg::CHAR_PLUS ||
                    rsp_code_char == b64se_pkg::CHAR_SLASH ||
                    rsp_code_char == b64se_pkg::PAD_CHAR)
   else $error("character outside alphabet");

   // a stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_char))
   else $error("stalled character changed");

   // output is empty at the first edge out of reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
   else $error("output valid after reset");

endmodule

bind base64_stream_encoder_core b64se_checker u_b64se_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_code_char      (rsp_code_char),
   .rsp_last_of_item   (rsp_last_of_item),
   .rsp_end_of_message (rsp_end_of_message)
);

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one raw byte waiting to be offered
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } raw_byte_type;

   // one character as it should leave the block
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       eom;
   } char_result_type;

   localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int TARGET_BYTES  = 270;
   localparam int MAX_WAIT      = 17;
   localparam int HOLD_AT_CHAR  = 120;
   localparam int HOLD_CYCLES   = 120;
   localparam int MAX_REPORTS   = 10;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte      = 8'h00;
   logic       req_final_byte     = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready          = 1'b0;
   logic [7:0] rsp_code_char;
   logic       rsp_last_of_item;
   logic       rsp_end_of_message;

   raw_byte_type    pending_bytes[$];
   char_result_type expected_chars[$];
   int              mismatch_count = 0;
   int              chars_taken    = 0;

   // encoder state as the block should hold it
   b64se_pkg::phase_type enc_phase = b64se_pkg::PH_FIRST;
   logic [3:0]           enc_carry = 4'h0;

   base64_stream_encoder_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_char      (rsp_code_char),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_end_of_message (rsp_end_of_message)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle cycles before the next item; calm stretches have none
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // expected characters for one accepted byte
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] chars[4];
      int         n;
      n = 0;
      case (enc_phase)
         b64se_pkg::PH_SECOND: begin
            chars[0] = B64_ALPHABET[{enc_carry[1:0], b[7:4]}];
            if (fin) begin
               chars[1]  = B64_ALPHABET[{b[3:0], 2'b00}];
               chars[2]  = b64se_pkg::PAD_CHAR;
               n         = 3;
               enc_phase = b64se_pkg::PH_FIRST;
               enc_carry = 4'h0;
            end else begin
               n         = 1;
               enc_phase = b64se_pkg::PH_THIRD;
               enc_carry = b[3:0];
            end
         end
         b64se_pkg::PH_THIRD: begin
            chars[0]  = B64_ALPHABET[{enc_carry, b[7:6]}];
            chars[1]  = B64_ALPHABET[b[5:0]];
            n         = 2;
            enc_phase = b64se_pkg::PH_FIRST;
            enc_carry = 4'h0;
         end
         default: begin
            chars[0] = B64_ALPHABET[b[7:2]];
            if (fin) begin
               chars[1]  = B64_ALPHABET[{b[1:0], 4'h0}];
               chars[2]  = b64se_pkg::PAD_CHAR;
               chars[3]  = b64se_pkg::PAD_CHAR;
               n         = 4;
               enc_phase = b64se_pkg::PH_FIRST;
               enc_carry = 4'h0;
            end else begin
               n         = 1;
               enc_phase = b64se_pkg::PH_SECOND;
               enc_carry = {2'b00, b[1:0]};
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         expected_chars.push_back('{chars[i], i == n - 1, (i == n - 1) && fin});
      end
   endtask

   task automatic note_mismatch(input string what, input char_result_type want,
                                input char_result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected char %h last %b eom %b, got char %h last %b eom %b",
                  $realtime, what, want.code, want.last, want.eom,
                  got.code, got.last, got.eom);
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      pending_bytes.push_back('{b, fin});
   endtask

   // request side: offer pending bytes with random gaps
   always @(posedge clock) begin : drive_req
      logic         offer;
      raw_byte_type nxt;
      int           send_gap;
      bit           send_calm;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_final_byte);
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_bytes.size() != 0) begin
               nxt             = pending_bytes.pop_front();
               req_data_byte  <= nxt.data;
               req_final_byte <= nxt.fin;
               offer           = 1'b1;
               send_gap        = draw_wait(send_calm);
            end
         end
         req_valid <= offer;
      end
   end

   // response side: check each character, stall at random, one long hold
   always @(posedge clock) begin : take_rsp
      logic            rdy;
      char_result_type got;
      int              take_stall;
      bit              take_calm;
      if (reset) begin
         rsp_ready  <= 1'b0;
         take_stall = 0;
      end else begin
         rdy = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_code_char, rsp_last_of_item, rsp_end_of_message};
            if (expected_chars.size() == 0) begin
               note_mismatch("unexpected char", '0, got);
            end else if (expected_chars[0] != got) begin
               note_mismatch("char mismatch", expected_chars.pop_front(), got);
            end else begin
               void'(expected_chars.pop_front());
            end
            chars_taken++;
            take_stall = (chars_taken == HOLD_AT_CHAR) ? HOLD_CYCLES
                                                       : draw_wait(take_calm);
            rdy = (take_stall == 0);
         end else if (!rsp_ready) begin
            if (take_stall > 0) begin
               take_stall--;
            end
            rdy = (take_stall == 0);
         end
         rsp_ready <= rdy;
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int total;
      int len;
      // one-byte messages: two pads
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      // two-byte messages: one pad
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // full group hitting '+' and '/'
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hBF, 1'b1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b1);
      // message ends at the start of a new group, then one byte into it
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte(8'h83, 1'b0);
      queue_byte(8'hA5, 1'b1);
      queue_byte(8'h14, 1'b0);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'h9C, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'hD9, 1'b1);
      total = 21;

      // random messages, mostly short, a few long
      while (total < TARGET_BYTES) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                           : $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            queue_byte(8'($urandom), i == len - 1);
         end
         total += len;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard limit on run time
   initial begin : watchdog
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
